>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the tessellator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define AST_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// next-cycle implication, disabled in reset
`define AST_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

// next-cycle implication, active through reset
`define AST_NEXT_NR(label, clk, a, b) \
   label: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared types and constants of the thick polyline tessellator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpt_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int JOB_DEPTH_DEF  = 4;
   localparam int THICK_BITS     = 31;
   localparam int CSR_IDX_BITS   = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_LINE_THICKNESS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLOSED_LOOP    = 2'd1;

   localparam logic [THICK_BITS-1:0] THICK_RESET = 31'd65536;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_FEW  = 2'd2;

   typedef struct packed {
      logic err;
      logic last;
   } job_ctrl_type;

endpackage

>>> hw/rtl/tpt_front.sv
// ----------------------------------------------------------------------------
// tpt_front
// Takes vertices, tracks the chain and issues segment or error jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpt_front import tpt_pkg::*; #(
   parameter int CW = COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 closed_loop,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic signed [CW-1:0] req_vertex_x,
   input  logic signed [CW-1:0] req_vertex_y,
   input  logic                 req_chain_end,
   output logic                 q_wr,
   output logic [4*CW-1:0]      q_data,
   output job_ctrl_type         q_ctrl,
   input  logic                 q_full
);

   logic [CW-1:0] prev_x_ff, prev_y_ff, first_x_ff, first_y_ff;
   logic [CW-1:0] prev_x_in, prev_y_in, first_x_in, first_y_in;
   logic [1:0]    seen_ff, seen_in;
   logic          pend_ff, pend_in;
   logic [4*CW-1:0] pend_data_ff, pend_data_in;

   logic acc, too_few, do_close;

   assign req_full = pend_ff | q_full;
   assign acc      = req_push & ~req_full;
   assign too_few  = req_chain_end & ((seen_ff == 2'd0) | (closed_loop & (seen_ff == 2'd1)));
   assign do_close = req_chain_end & closed_loop &
                     ((req_vertex_x != first_x_ff) | (req_vertex_y != first_y_ff));

   always_comb begin
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      seen_in      = seen_ff;
      pend_in      = pend_ff;
      pend_data_in = pend_data_ff;
      q_wr         = 1'b0;
      q_data       = pend_data_ff;
      q_ctrl       = '{err: 1'b0, last: 1'b1};
      if (acc) begin
         if (too_few) begin
            q_wr    = 1'b1;
            q_ctrl  = '{err: 1'b1, last: 1'b1};
            seen_in = 2'd0;
         end else begin
            if (seen_ff == 2'd0) begin
               first_x_in = req_vertex_x;
               first_y_in = req_vertex_y;
            end else begin
               q_wr   = 1'b1;
               q_data = {prev_x_ff, prev_y_ff, req_vertex_x, req_vertex_y};
               q_ctrl = '{err: 1'b0, last: ~do_close};
            end
            if (do_close) begin
               pend_in      = 1'b1;
               pend_data_in = {req_vertex_x, req_vertex_y, first_x_ff, first_y_ff};
            end
            prev_x_in = req_vertex_x;
            prev_y_in = req_vertex_y;
            if (req_chain_end) begin
               seen_in = 2'd0;
            end else if (seen_ff != 2'd3) begin
               seen_in = seen_ff + 2'd1;
            end
         end
      end else if (pend_ff && !q_full) begin
         q_wr    = 1'b1;
         q_data  = pend_data_ff;
         q_ctrl  = '{err: 1'b0, last: 1'b1};
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         first_x_ff <= '0;
         first_y_ff <= '0;
         seen_ff    <= 2'd0;
         pend_ff    <= 1'b0;
      end else begin
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         seen_ff    <= seen_in;
         pend_ff    <= pend_in;
      end
      pend_data_ff <= pend_data_in;
   end

endmodule

>>> hw/rtl/tpt_job_queue.sv
// ----------------------------------------------------------------------------
// tpt_job_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpt_job_queue import tpt_pkg::*; #(
   parameter int W     = 4 * COORD_BITS_DEF,
   parameter int DEPTH = JOB_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         wr,
   input  logic [W-1:0] wr_data,
   input  job_ctrl_type wr_ctrl,
   output logic         full,
   input  logic         rd,
   output logic [W-1:0] rd_data,
   output job_ctrl_type rd_ctrl,
   output logic         empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [W-1:0]  data_mem [DEPTH];
   job_ctrl_type  ctrl_mem [DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          do_wr, do_rd;

   assign full    = (cnt_ff == NW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_wr   = wr & ~full;
   assign do_rd   = rd & ~empty;
   assign rd_data = data_mem[rp_ff];
   assign rd_ctrl = ctrl_mem[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_wr) wp_in = (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + PW'(1);
      if (do_rd) rp_in = (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + PW'(1);
      if (do_wr && !do_rd) cnt_in = cnt_ff + NW'(1);
      else if (do_rd && !do_wr) cnt_in = cnt_ff - NW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_wr) begin
         data_mem[wp_ff] <= wr_data;
         ctrl_mem[wp_ff] <= wr_ctrl;
      end
   end

endmodule

>>> hw/rtl/tpt_back.sv
// ----------------------------------------------------------------------------
// tpt_back
// Segment engine: normalize, square root, divide, scale, emit six corners.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpt_back import tpt_pkg::*; #(
   parameter int CW = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [THICK_BITS-1:0] thickness,
   input  logic                  q_empty,
   output logic                  q_rd,
   input  logic [4*CW-1:0]       q_data,
   input  job_ctrl_type          q_ctrl,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic signed [CW-1:0]  rsp_out_x,
   output logic signed [CW-1:0]  rsp_out_y,
   output logic [1:0]            rsp_status,
   output logic                  rsp_run_last
);

   localparam int MW = (CW + 1 > 31) ? CW + 1 : 31;
   localparam int EW = ((CW > 32) ? CW : 32) + 2;

   typedef enum logic [10:0] {
      S_IDLE = 11'b00000000001,
      S_NORM = 11'b00000000010,
      S_SQX  = 11'b00000000100,
      S_SQY  = 11'b00000001000,
      S_SUM  = 11'b00000010000,
      S_ROOT = 11'b00000100000,
      S_DIVI = 11'b00001000000,
      S_DIV  = 11'b00010000000,
      S_MUL  = 11'b00100000000,
      S_EMIT = 11'b01000000000,
      S_ERR  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic signed [CW-1:0] px_ff, py_ff, qx_ff, qy_ff, px_in, py_in, qx_in, qy_in;
   job_ctrl_type ctrl_ff, ctrl_in;
   logic [1:0]    st_ff, st_in;
   logic [MW-1:0] ax_ff, ay_ff, ax_in, ay_in;
   logic          negx_ff, negy_ff, negx_in, negy_in;
   logic [61:0]   sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic [63:0]   rem_ff, res_ff, bit_ff, rem_in, res_in, bit_in;
   logic          sel_ff, sel_in;
   logic [31:0]   num_ff, drem_ff, quo_ff, num_in, drem_in, quo_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [30:0]   nx_ff, ny_ff, nx_in, ny_in;

   logic                 out_valid_ff, out_valid_in;
   logic signed [CW-1:0] out_x_ff, out_y_ff, out_x_in, out_y_in;
   logic [1:0]           out_st_ff, out_st_in;
   logic                 out_last_ff, out_last_in;

   logic signed [CW-1:0] jpx, jpy, jqx, jqy;
   logic signed [CW:0]   dx, dy;
   logic [CW:0]          absx, absy;
   logic [MW-1:0]        maxv;
   logic [30:0]          mul_a, mul_b;
   logic [61:0]          prod;
   logic [63:0]          root_t;
   logic [61:0]          num;
   logic [32:0]          r2, len33;
   logic [30:0]          uc;
   logic [61:0]          nsum;
   logic signed [EW-1:0] nxs, nys, bx, by, tx, ty;
   logic                 use_q, plus;
   logic                 out_free;

   function automatic logic [CW-1:0] sat(input logic signed [EW-1:0] v);
      logic [EW-CW:0] hi;
      hi = v[EW-1:CW-1];
      if ((&hi) | ~(|hi)) sat = v[CW-1:0];
      else if (v[EW-1]) sat = {1'b1, {(CW-1){1'b0}}};
      else sat = {1'b0, {(CW-1){1'b1}}};
   endfunction

   assign jpx  = q_data[4*CW-1 -: CW];
   assign jpy  = q_data[3*CW-1 -: CW];
   assign jqx  = q_data[2*CW-1 -: CW];
   assign jqy  = q_data[CW-1:0];
   assign dx   = (CW+1)'(jqx) - (CW+1)'(jpx);
   assign dy   = (CW+1)'(jqy) - (CW+1)'(jpy);
   assign absx = dx[CW] ? $unsigned(-dx) : $unsigned(dx);
   assign absy = dy[CW] ? $unsigned(-dy) : $unsigned(dy);
   assign maxv = (ax_ff > ay_ff) ? ax_ff : ay_ff;

   assign uc = (quo_ff > 32'h4000_0000) ? 31'h4000_0000 : quo_ff[30:0];

   always_comb begin
      mul_a = uc;
      mul_b = thickness;
      if (state_ff == S_SQX) begin
         mul_a = ax_ff[30:0];
         mul_b = ax_ff[30:0];
      end else if (state_ff == S_SQY) begin
         mul_a = ay_ff[30:0];
         mul_b = ay_ff[30:0];
      end
   end
   assign prod   = mul_a * mul_b;
   assign nsum   = prod + 62'h4000_0000;
   assign root_t = res_ff + bit_ff;
   assign num    = {(sel_ff ? ay_ff[30:0] : ax_ff[30:0]), 30'd0} + 62'(res_ff[31:1]);
   assign r2     = {drem_ff, num_ff[31]};
   assign len33  = {1'b0, res_ff[31:0]};

   // corner select: e0 e1 e2 e0 e2 e3
   always_comb begin
      unique case (cnt_ff[2:0])
         3'd0:    begin use_q = 1'b0; plus = 1'b1; end
         3'd1:    begin use_q = 1'b0; plus = 1'b0; end
         3'd2:    begin use_q = 1'b1; plus = 1'b0; end
         3'd3:    begin use_q = 1'b0; plus = 1'b1; end
         3'd4:    begin use_q = 1'b1; plus = 1'b0; end
         3'd5:    begin use_q = 1'b1; plus = 1'b1; end
         default: begin use_q = 1'b0; plus = 1'b0; end
      endcase
   end
   assign nxs = negx_ff ? -$signed(EW'(nx_ff)) : $signed(EW'(nx_ff));
   assign nys = negy_ff ? -$signed(EW'(ny_ff)) : $signed(EW'(ny_ff));
   assign bx  = use_q ? EW'(qx_ff) : EW'(px_ff);
   assign by  = use_q ? EW'(qy_ff) : EW'(py_ff);
   assign tx  = bx + (plus ? nys : -nys);
   assign ty  = by + (plus ? -nxs : nxs);

   assign out_free = ~out_valid_ff | rsp_pop;
   assign q_rd     = (state_ff == S_IDLE) & ~q_empty;

   always_comb begin
      state_in = state_ff;
      px_in = px_ff; py_in = py_ff; qx_in = qx_ff; qy_in = qy_ff;
      ctrl_in = ctrl_ff; st_in = st_ff;
      ax_in = ax_ff; ay_in = ay_ff; negx_in = negx_ff; negy_in = negy_ff;
      sqx_in = sqx_ff; sqy_in = sqy_ff;
      rem_in = rem_ff; res_in = res_ff; bit_in = bit_ff;
      sel_in = sel_ff; num_in = num_ff; drem_in = drem_ff; quo_in = quo_ff;
      cnt_in = cnt_ff; nx_in = nx_ff; ny_in = ny_ff;
      out_x_in = out_x_ff; out_y_in = out_y_ff;
      out_st_in = out_st_ff; out_last_in = out_last_ff;
      out_valid_in = rsp_pop ? 1'b0 : out_valid_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               px_in = jpx; py_in = jpy; qx_in = jqx; qy_in = jqy;
               ctrl_in = q_ctrl;
               ax_in = MW'(absx); ay_in = MW'(absy);
               negx_in = dx[CW]; negy_in = dy[CW];
               nx_in = '0; ny_in = '0; sel_in = 1'b0; cnt_in = '0;
               if (q_ctrl.err) begin
                  state_in = S_ERR;
               end else if (dx == '0 && dy == '0) begin
                  st_in = ST_ZERO;
                  state_in = S_EMIT;
               end else begin
                  st_in = ST_OK;
                  state_in = S_NORM;
               end
            end
         end
         S_NORM: begin
            if ((maxv >> 31) != '0) begin
               ax_in = ax_ff >> 1;
               ay_in = ay_ff >> 1;
            end else if (!maxv[30]) begin
               ax_in = ax_ff << 1;
               ay_in = ay_ff << 1;
            end else begin
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            sqx_in = prod;
            state_in = S_SQY;
         end
         S_SQY: begin
            sqy_in = prod;
            state_in = S_SUM;
         end
         S_SUM: begin
            rem_in = 64'(sqx_ff) + 64'(sqy_ff);
            res_in = '0;
            bit_in = 64'h4000_0000_0000_0000;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (rem_ff >= root_t) begin
               rem_in = rem_ff - root_t;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == 64'd1) state_in = S_DIVI;
         end
         S_DIVI: begin
            drem_in = 32'(num[61:32]);
            num_in = num[31:0];
            quo_in = '0;
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (r2 >= len33) begin
               drem_in = 32'(r2 - len33);
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               drem_in = r2[31:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
            num_in = {num_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = S_MUL;
         end
         S_MUL: begin
            if (sel_ff) begin
               ny_in = nsum[61:31];
               cnt_in = '0;
               state_in = S_EMIT;
            end else begin
               nx_in = nsum[61:31];
               sel_in = 1'b1;
               state_in = S_DIVI;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_x_in = sat(tx);
               out_y_in = sat(ty);
               out_st_in = st_ff;
               out_last_in = (cnt_ff == 5'd5) & ctrl_ff.last;
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == 5'd5) state_in = S_IDLE;
            end
         end
         S_ERR: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_x_in = '0;
               out_y_in = '0;
               out_st_in = ST_FEW;
               out_last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      px_ff <= px_in; py_ff <= py_in; qx_ff <= qx_in; qy_ff <= qy_in;
      ctrl_ff <= ctrl_in; st_ff <= st_in;
      ax_ff <= ax_in; ay_ff <= ay_in; negx_ff <= negx_in; negy_ff <= negy_in;
      sqx_ff <= sqx_in; sqy_ff <= sqy_in;
      rem_ff <= rem_in; res_ff <= res_in; bit_ff <= bit_in;
      sel_ff <= sel_in; num_ff <= num_in; drem_ff <= drem_in; quo_ff <= quo_in;
      cnt_ff <= cnt_in; nx_ff <= nx_in; ny_ff <= ny_in;
      out_x_ff <= out_x_in; out_y_ff <= out_y_in;
      out_st_ff <= out_st_in; out_last_ff <= out_last_in;
   end

   assign rsp_empty    = ~out_valid_ff;
   assign rsp_out_x    = out_x_ff;
   assign rsp_out_y    = out_y_ff;
   assign rsp_status   = out_st_ff;
   assign rsp_run_last = out_last_ff;

endmodule

>>> hw/rtl/thick_polyline_tessellator.sv
// ----------------------------------------------------------------------------
// thick_polyline_tessellator
// Expands polyline segments into two triangles each, offset by half width.
//
//   channel  | direction | transfer when
//   req_*    | in        | req_push & !req_full
//   rsp_*    | out       | rsp_pop & !rsp_empty
//   csr_*    | in        | csr_wr_en
//
// The back engine takes a job, normalizes, squares and sums, takes the root,
// divides and scales each normal component in turn and emits six corners. A
// zero-length segment goes straight to emit; a too-few error emits one word.
// A 4-entry job queue lets the front keep taking vertices while the back works;
// req_full rises when it is full or a closing job waits. Synchronous active-high
// reset; no clearing pass. A stalled rsp_pop holds the engine in emit or error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thick_polyline_tessellator import tpt_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int JOB_DEPTH  = JOB_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [THICK_BITS-1:0]        csr_wr_data,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [COORD_BITS-1:0] req_vertex_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_y,
   input  logic                         req_chain_end,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_run_last
);

   logic [THICK_BITS-1:0] thick_ff;
   logic                  loop_ff;

   logic                    q_wr, q_full, q_rd, q_empty;
   logic [4*COORD_BITS-1:0] q_wdata, q_rdata;
   job_ctrl_type            q_wctrl, q_rctrl;

   always_ff @(posedge clock) begin
      if (reset) begin
         thick_ff <= THICK_RESET;
         loop_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_LINE_THICKNESS) thick_ff <= csr_wr_data;
         if (csr_index == CSR_CLOSED_LOOP) loop_ff <= csr_wr_data[0];
      end
   end

   tpt_front #(.CW(COORD_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .closed_loop   (loop_ff),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_vertex_x  (req_vertex_x),
      .req_vertex_y  (req_vertex_y),
      .req_chain_end (req_chain_end),
      .q_wr          (q_wr),
      .q_data        (q_wdata),
      .q_ctrl        (q_wctrl),
      .q_full        (q_full)
   );

   tpt_job_queue #(.W(4 * COORD_BITS), .DEPTH(JOB_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (q_wr),
      .wr_data (q_wdata),
      .wr_ctrl (q_wctrl),
      .full    (q_full),
      .rd      (q_rd),
      .rd_data (q_rdata),
      .rd_ctrl (q_rctrl),
      .empty   (q_empty)
   );

   tpt_back #(.CW(COORD_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .thickness    (thick_ff),
      .q_empty      (q_empty),
      .q_rd         (q_rd),
      .q_data       (q_rdata),
      .q_ctrl       (q_rctrl),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_status   (rsp_status),
      .rsp_run_last (rsp_run_last)
   );

endmodule

>>> hw/rtl/tpt_checker.sv
// ----------------------------------------------------------------------------
// tpt_checker
// Port-level checks of the tessellator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpt_checker import tpt_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input logic [COORD_BITS-1:0] rsp_out_x,
   input logic [COORD_BITS-1:0] rsp_out_y,
   input logic [1:0]            rsp_status,
   input logic                  rsp_run_last
);

   logic                    held, is_few, few_ok;
   logic [2*COORD_BITS+2:0] rsp_word;
   assign held     = ~rsp_empty & ~rsp_pop;
   assign rsp_word = {rsp_out_x, rsp_out_y, rsp_status, rsp_run_last};
   assign is_few   = ~rsp_empty & (rsp_status == ST_FEW);
   assign few_ok   = rsp_run_last & (rsp_out_x == '0) & (rsp_out_y == '0);

   `AST_NEXT_NR(a_reset_empty, clock, reset, rsp_empty)
   `AST_NEXT(a_rsp_hold, clock, reset, held, !rsp_empty && $stable(rsp_word))
   `AST_IMPLY(a_status_code, clock, reset, !rsp_empty, rsp_status != 2'd3)
   `AST_IMPLY(a_error_alone, clock, reset, is_few, few_ok)

endmodule

bind thick_polyline_tessellator tpt_checker #(.COORD_BITS(COORD_BITS)) u_tpt_checker (.*);

>>> tb/thick_polyline_tessellator_tb.sv
// ----------------------------------------------------------------------------
// thick_polyline_tessellator_tb
// Self-checking bench: a queued driver pushes polyline vertices, a clocked
// monitor pops triangle corners and checks them against a built-in
// fixed-point predictor of the segment expansion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thick_polyline_tessellator_tb;
   import tpt_pkg::*;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               ce;
   } vertex_type;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [1:0]         st;
      logic               last;
   } corner_type;

   localparam logic signed [31:0] CMAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] CMIN = 32'sh80000000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [THICK_BITS-1:0]   csr_wr_data = '0;
   logic                    req_push = 1'b0;
   logic                    req_full;
   logic signed [31:0]      req_vertex_x = '0;
   logic signed [31:0]      req_vertex_y = '0;
   logic                    req_chain_end = 1'b0;
   logic                    rsp_empty;
   logic                    rsp_pop = 1'b0;
   logic signed [31:0]      rsp_out_x;
   logic signed [31:0]      rsp_out_y;
   logic [1:0]              rsp_status;
   logic                    rsp_run_last;

   vertex_type pending_vertices[$];
   corner_type corners_due[$];
   vertex_type cur_vertex;

   // predictor state
   logic [30:0]        thick_q = THICK_RESET;
   logic               loop_q = 1'b0;
   logic signed [31:0] prev_x = '0, prev_y = '0, first_x = '0, first_y = '0;
   logic [1:0]         seen = '0;

   int  mismatches = 0;
   bit  quiet = 1'b0;
   bit  hold_start = 1'b0;
   int  hold_left = 0;
   int  send_gap = 0;
   int  take_gap = 0;

   thick_polyline_tessellator DUT (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .req_push(req_push), .req_full(req_full),
      .req_vertex_x(req_vertex_x), .req_vertex_y(req_vertex_y),
      .req_chain_end(req_chain_end),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_status(rsp_status), .rsp_run_last(rsp_run_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return CMAX;
      if (v < -64'sd2147483648) return CMIN;
      return v[31:0];
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint normal_offset(longint unsigned mag, bit neg,
                                            longint unsigned len);
      longint unsigned u, n;
      u = ((mag << 30) + (len >> 1)) / len;
      if (u > (64'd1 << 30)) u = 64'd1 << 30;
      n = (u * longint'(thick_q) + (64'd1 << 30)) >> 31;
      return neg ? -longint'(n) : longint'(n);
   endfunction

   task automatic expect_corner(corner_type c);
      corners_due.insert(corners_due.size(), c);
   endtask

   task automatic expand_segment(longint px, longint py, longint qx, longint qy);
      longint dx, dy, nx, ny;
      longint unsigned ax, ay, len;
      logic [1:0] st;
      corner_type e[4];
      dx = qx - px;
      dy = qy - py;
      nx = 0;
      ny = 0;
      st = ST_OK;
      if (dx == 0 && dy == 0) begin
         st = ST_ZERO;
      end else begin
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         while ((ax > ay ? ax : ay) >= (64'd1 << 31)) begin
            ax = ax >> 1;
            ay = ay >> 1;
         end
         while ((ax > ay ? ax : ay) < (64'd1 << 30)) begin
            ax = ax << 1;
            ay = ay << 1;
         end
         len = int_sqrt(ax * ax + ay * ay);
         nx = normal_offset(ax, dx < 0, len);
         ny = normal_offset(ay, dy < 0, len);
      end
      e[0] = '{clamp32(px + ny), clamp32(py - nx), st, 1'b0};
      e[1] = '{clamp32(px - ny), clamp32(py + nx), st, 1'b0};
      e[2] = '{clamp32(qx - ny), clamp32(qy + nx), st, 1'b0};
      e[3] = '{clamp32(qx + ny), clamp32(qy - nx), st, 1'b0};
      expect_corner(e[0]);
      expect_corner(e[1]);
      expect_corner(e[2]);
      expect_corner(e[0]);
      expect_corner(e[2]);
      expect_corner(e[3]);
   endtask

   task automatic tessellate_vertex(vertex_type v);
      int before_n, total;
      corner_type c;
      before_n = corners_due.size();
      total = seen + 1;
      if (v.ce && (total < 2 || (loop_q && total < 3))) begin
         c = '{32'sd0, 32'sd0, ST_FEW, 1'b1};
         expect_corner(c);
         seen = 0;
      end else begin
         if (seen == 0) begin
            first_x = v.x;
            first_y = v.y;
         end else begin
            expand_segment(prev_x, prev_y, v.x, v.y);
         end
         if (v.ce && loop_q && (v.x != first_x || v.y != first_y))
            expand_segment(v.x, v.y, first_x, first_y);
         prev_x = v.x;
         prev_y = v.y;
         if (v.ce) seen = 0;
         else if (seen < 3) seen = seen + 1;
         if (corners_due.size() > before_n) begin
            c = corners_due.pop_back();
            c.last = 1'b1;
            expect_corner(c);
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) tessellate_vertex(cur_vertex);
         if (!req_push || !req_full) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_push <= 1'b0;
            end else if (pending_vertices.size() != 0 && !quiet &&
                         $urandom_range(0, 6) == 0) begin
               send_gap <= $urandom_range(1, 11) - 1;
               req_push <= 1'b0;
            end else if (pending_vertices.size() != 0) begin
               cur_vertex = pending_vertices.pop_front();
               req_push <= 1'b1;
               req_vertex_x <= cur_vertex.x;
               req_vertex_y <= cur_vertex.y;
               req_chain_end <= cur_vertex.ce;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_start) hold_left <= 2000;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // monitor
   always @(posedge clock) begin
      corner_type c;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (corners_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: x=%0d y=%0d st=%0d last=%0b",
                        rsp_out_x, rsp_out_y, rsp_status, rsp_run_last);
         end else begin
            c = corners_due.pop_front();
            if (c.x !== rsp_out_x || c.y !== rsp_out_y || c.st !== rsp_status ||
                c.last !== rsp_run_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp x=%0d y=%0d st=%0d last=%0b,",
                           c.x, c.y, c.st, c.last,
                           " got x=%0d y=%0d st=%0d last=%0b",
                           rsp_out_x, rsp_out_y, rsp_status, rsp_run_last);
            end
         end
      end
      if (reset || hold_left != 0) begin
         rsp_pop <= 1'b0;
      end else if (take_gap > 0) begin
         take_gap <= take_gap - 1;
         rsp_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
         take_gap <= $urandom_range(1, 11) - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   initial begin
      #20ms;
      $display("thick_polyline_tessellator_tb: FAIL");
      $finish;
   end

   task automatic add_vertex(logic signed [31:0] x, logic signed [31:0] y, logic ce);
      vertex_type v;
      v = '{x, y, ce};
      pending_vertices.insert(pending_vertices.size(), v);
   endtask

   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [30:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_LINE_THICKNESS) thick_q = data;
      else if (idx == CSR_CLOSED_LOOP) loop_q = data[0];
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_vertices.size() != 0 || req_push || corners_due.size() != 0)
         @(negedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
         2: return $urandom_range(0, 1) ? CMAX : CMIN;
         default: return $signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000;
      endcase
   endfunction

   task automatic rand_chain(output int n);
      logic signed [31:0] fx, fy, px, py, x, y;
      int k;
      n = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 6);
      for (k = 0; k < n; k++) begin
         x = rand_coord();
         y = rand_coord();
         if (k > 0 && $urandom_range(0, 6) == 0) begin
            x = px;
            y = py;
         end
         if (k == 0) begin
            fx = x;
            fy = y;
         end else if (k == n - 1 && $urandom_range(0, 4) == 0) begin
            x = fx;
            y = fy;
         end
         add_vertex(x, y, k == n - 1);
         px = x;
         py = y;
      end
   endtask

   initial begin
      int phase, sent, n;
      logic [30:0] th;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // open chains at reset thickness
      add_vertex(32'sd0, 32'sd0, 1'b0);
      add_vertex(32'sh000A0000, 32'sd0, 1'b1);
      add_vertex(32'sd5, 32'sd5, 1'b0);
      add_vertex(32'sd5, 32'sd5, 1'b1);
      add_vertex(32'sd7, -32'sd7, 1'b1);
      add_vertex(CMAX, CMAX, 1'b0);
      add_vertex(CMIN, CMIN, 1'b0);
      add_vertex(CMIN, CMAX, 1'b0);
      add_vertex(-32'sd1, 32'sd1, 1'b1);
      drain();

      csr_write(2'd2, 31'h12345);
      csr_write(2'd3, '1);
      csr_write(CSR_LINE_THICKNESS, 31'h7FFFFFFF);
      csr_write(CSR_CLOSED_LOOP, 31'h1);
      add_vertex(32'sd0, 32'sd0, 1'b0);
      add_vertex(32'sh00100000, 32'sd0, 1'b0);
      add_vertex(32'sd0, 32'sh00100000, 1'b1);
      add_vertex(32'sd3, 32'sd4, 1'b0);
      add_vertex(32'sd9, 32'sd9, 1'b1);
      add_vertex(32'sd1, 32'sd2, 1'b0);
      add_vertex(32'sd8, -32'sd2, 1'b0);
      add_vertex(32'sd1, 32'sd2, 1'b1);
      drain();

      // loop mode switched in the middle of a chain
      csr_write(CSR_CLOSED_LOOP, 31'h0);
      add_vertex(32'sh00020000, 32'sh00030000, 1'b0);
      add_vertex(-32'sh00040000, 32'sh00010000, 1'b0);
      drain();
      csr_write(CSR_CLOSED_LOOP, 31'h7FFFFFFF);
      csr_write(CSR_LINE_THICKNESS, 31'h0);
      add_vertex(32'sh00050000, -32'sh00060000, 1'b1);
      drain();

      for (phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 3))
            0: th = 31'h7FFFFFFF;
            1: th = 31'h0;
            2: th = 31'($urandom_range(0, 32'h7FFFFFFF));
            default: th = 31'($urandom_range(0, 32'h0003FFFF));
         endcase
         csr_write(CSR_LINE_THICKNESS, th);
         csr_write(CSR_CLOSED_LOOP, 31'($urandom()));
         if (phase == 5) quiet = 1'b1;
         if (phase == 2) begin
            @(posedge clock);
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         sent = 0;
         while (sent < 40) begin
            rand_chain(n);
            sent += n;
         end
         drain();
      end

      if (mismatches == 0 && corners_due.size() == 0)
         $display("thick_polyline_tessellator_tb: PASS");
      else
         $display("thick_polyline_tessellator_tb: FAIL");
      $finish;
   end

endmodule
